@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the cull and depth bucket sorter.
// Every assertion samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check with reset disable.
`define CDBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define CDBS_NEVER(lbl, cond, msg) \
  `CDBS_ASSERT(lbl, !(cond), msg)

`endif

@@ src/cdbs_pkg.sv @@
// Shared constants, codes and controller/datapath handshake structs
// for the cull and depth bucket sorter. No dependencies.
package cdbs_pkg;

  localparam int BUCKETS    = 64;
  localparam int BUCKET_CAP = 128;
  localparam int MAX_TRIS   = 1024;

  localparam int BK_W     = $clog2(BUCKETS);
  localparam int SLOT_W   = $clog2(BUCKET_CAP);      // entry address = {bucket, slot}
  localparam int FILL_W   = $clog2(BUCKET_CAP + 1);
  localparam int ID_W     = $clog2(MAX_TRIS);
  localparam int COORD_W  = 12;
  localparam int DEPTH_W  = 16;
  localparam int SHIFT_W  = 4;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int PROD_W   = 2 * (COORD_W + 1);
  localparam int ENTRY_AW = BK_W + SLOT_W;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CULLED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;        // capture input word, products and bucket
    logic ins_rd;      // read fill count of insert bucket
    logic ins_fin;     // commit insert, emit stored/full
    logic emit_cull;   // emit culled
    logic emit_clr;    // clear buckets, emit cleared
    logic pop_look;    // read fill count of cursor bucket
    logic pop_dec;     // step cursor down one bucket
    logic ent_rd;      // read entry at cursor
    logic pop_fin;     // emit popped entry, advance slot
    logic emit_empty;  // emit empty
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            culled;
    logic            nz_cur;
    logic            pb_zero;
    logic            slot_lt_fill;
    logic            out_free;
  } sts_t;

endpackage

@@ src/cdbs_if.sv @@
// Valid/ready channel interfaces for the cull and depth bucket sorter:
// triangle/op input words and result words. Depends on cdbs_pkg.
interface cdbs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [cdbs_pkg::OP_W-1:0]      op;
  logic        [cdbs_pkg::ID_W-1:0]      tri_id;
  logic signed [cdbs_pkg::COORD_W-1:0]   ax;
  logic signed [cdbs_pkg::COORD_W-1:0]   ay;
  logic signed [cdbs_pkg::COORD_W-1:0]   bx;
  logic signed [cdbs_pkg::COORD_W-1:0]   by;
  logic signed [cdbs_pkg::COORD_W-1:0]   cx;
  logic signed [cdbs_pkg::COORD_W-1:0]   cy;
  logic signed [cdbs_pkg::DEPTH_W-1:0]   depth0;
  logic signed [cdbs_pkg::DEPTH_W-1:0]   depth1;
  logic signed [cdbs_pkg::DEPTH_W-1:0]   depth2;

  modport source (output valid, op, tri_id, ax, ay, bx, by, cx, cy,
                  depth0, depth1, depth2, input ready);
  modport sink   (input valid, op, tri_id, ax, ay, bx, by, cx, cy,
                  depth0, depth1, depth2, output ready);
endinterface

interface cdbs_out_if;
  logic                              valid;
  logic                              ready;
  logic [cdbs_pkg::STATUS_W-1:0]     status;
  logic [cdbs_pkg::ID_W-1:0]         out_tri_id;
  logic [cdbs_pkg::BK_W-1:0]         out_bucket;
  logic                              last;

  modport source (output valid, status, out_tri_id, out_bucket, last, input ready);
  modport sink   (input valid, status, out_tri_id, out_bucket, last, output ready);
endinterface

@@ src/cdbs_ctrl.sv @@
// Sequencing state machine of the cull and depth bucket sorter.
// Depends on cdbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cdbs_pkg::sts_t   sts_i,
  output cdbs_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DEC      = 3'd1;
  localparam logic [2:0] S_INS_WR   = 3'd2;
  localparam logic [2:0] S_POP_LOOK = 3'd3;
  localparam logic [2:0] S_POP_CHK  = 3'd4;
  localparam logic [2:0] S_POP_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [$bits(cdbs_pkg::cmd_t)-1:0] cmd_bits;
  logic emit_any;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.op)
          cdbs_pkg::OP_INSERT: begin
            if (sts_i.culled) begin
              if (sts_i.out_free) begin
                cmd_o.emit_cull = 1'b1;
                state_d         = S_IDLE;
              end
            end else begin
              cmd_o.ins_rd = 1'b1;
              state_d      = S_INS_WR;
            end
          end
          cdbs_pkg::OP_CLEAR: begin
            if (sts_i.out_free) begin
              cmd_o.emit_clr = 1'b1;
              state_d        = S_IDLE;
            end
          end
          cdbs_pkg::OP_POP:  state_d = S_POP_LOOK;
          cdbs_pkg::OP_NONE: state_d = S_IDLE;
          default:           state_d = S_IDLE;
        endcase
      end
      S_INS_WR: begin
        if (sts_i.out_free) begin
          cmd_o.ins_fin = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_POP_LOOK: begin
        // empty buckets are skipped from the valid bits, no read needed
        priority if (sts_i.nz_cur) begin
          cmd_o.pop_look = 1'b1;
          state_d        = S_POP_CHK;
        end else if (!sts_i.pb_zero) begin
          cmd_o.pop_dec = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end else begin
          // empty result waits for the output register
          state_d = S_POP_LOOK;
        end
      end
      S_POP_CHK: begin
        priority if (sts_i.slot_lt_fill) begin
          cmd_o.ent_rd = 1'b1;
          state_d      = S_POP_OUT;
        end else if (!sts_i.pb_zero) begin
          cmd_o.pop_dec = 1'b1;
          state_d       = S_POP_LOOK;
        end else if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end else begin
          state_d = S_POP_CHK;
        end
      end
      S_POP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.pop_fin = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_bits = cmd_o;
  assign emit_any = cmd_o.emit_cull | cmd_o.emit_clr | cmd_o.ins_fin |
                    cmd_o.pop_fin | cmd_o.emit_empty;

  `CDBS_ASSERT(a_cmd_onehot0, $onehot0(cmd_bits), "more than one command in a cycle")
  `CDBS_NEVER(a_emit_blocked, emit_any && !sts_i.out_free, "result emitted into a full output")
  `CDBS_ASSERT(a_accept_dec, in_valid_i && in_ready_o |=> state_q == S_DEC,
               "accepted word not decoded")

endmodule

@@ src/cdbs_dp.sv @@
// Datapath of the cull and depth bucket sorter: edge products, bucket
// select, fill-count and entry memories, pop cursor and result register.
// Depends on cdbs_pkg, cdbs_if and assert_macros.svh.
`include "assert_macros.svh"

module cdbs_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cdbs_pkg::SHIFT_W-1:0]      cfg_wdata_i,
  cdbs_in_if.sink                           in_i,
  cdbs_out_if.source                        out_o,
  input  cdbs_pkg::cmd_t                    cmd_i,
  output cdbs_pkg::sts_t                    sts_o
);

  localparam int ZSUM_W = cdbs_pkg::DEPTH_W + 2;
  localparam int ZQ_W   = ZSUM_W - 1;

  // input side
  logic signed [cdbs_pkg::COORD_W:0]     dbx, dby, dcx, dcy;
  logic signed [cdbs_pkg::PROD_W-1:0]    p1_d, p2_d;
  logic signed [cdbs_pkg::PROD_W-1:0]    p1_q, p2_q;
  logic signed [cdbs_pkg::PROD_W:0]      edge_fn;
  logic signed [ZSUM_W-1:0]              zsum;
  logic        [ZQ_W-1:0]                zq;
  logic        [cdbs_pkg::BK_W-1:0]      bk_d, bk_q;
  logic        [cdbs_pkg::OP_W-1:0]      op_q;
  logic        [cdbs_pkg::ID_W-1:0]      id_q;
  logic        [cdbs_pkg::SHIFT_W-1:0]   shift_q;

  // bucket state
  logic [cdbs_pkg::FILL_W-1:0]  fill_mem [cdbs_pkg::BUCKETS];
  logic [cdbs_pkg::ID_W-1:0]    entry_mem [2**cdbs_pkg::ENTRY_AW];
  logic [cdbs_pkg::BUCKETS-1:0] nz_q;
  logic [cdbs_pkg::FILL_W-1:0]  fill_rd_q, fill_eff, fill_inc;
  logic                         fill_vld_q;
  logic [cdbs_pkg::BK_W-1:0]    fill_addr;
  logic [cdbs_pkg::ID_W-1:0]    ent_q;
  logic [cdbs_pkg::BK_W-1:0]    pb_q;
  logic [cdbs_pkg::FILL_W-1:0]  slot_q;
  logic [cdbs_pkg::FILL_W:0]    slot_nxt;
  logic [cdbs_pkg::BUCKETS-1:0] low_mask;
  logic                         full, more_here, more_below, last_d;

  // result register
  logic                          out_valid_q;
  logic [cdbs_pkg::STATUS_W-1:0] status_q;
  logic [cdbs_pkg::ID_W-1:0]     out_id_q;
  logic [cdbs_pkg::BK_W-1:0]     out_bk_q;
  logic                          last_q;
  logic                          emit;

  // edge function products
  assign dbx  = {in_i.bx[cdbs_pkg::COORD_W-1], in_i.bx} - {in_i.ax[cdbs_pkg::COORD_W-1], in_i.ax};
  assign dby  = {in_i.by[cdbs_pkg::COORD_W-1], in_i.by} - {in_i.ay[cdbs_pkg::COORD_W-1], in_i.ay};
  assign dcx  = {in_i.cx[cdbs_pkg::COORD_W-1], in_i.cx} - {in_i.ax[cdbs_pkg::COORD_W-1], in_i.ax};
  assign dcy  = {in_i.cy[cdbs_pkg::COORD_W-1], in_i.cy} - {in_i.ay[cdbs_pkg::COORD_W-1], in_i.ay};
  assign p1_d = cdbs_pkg::PROD_W'(dbx) * cdbs_pkg::PROD_W'(dcy);
  assign p2_d = cdbs_pkg::PROD_W'(dby) * cdbs_pkg::PROD_W'(dcx);
  assign edge_fn = (cdbs_pkg::PROD_W + 1)'(p1_q) - (cdbs_pkg::PROD_W + 1)'(p2_q);

  // bucket from depth sum: negative -> 0, else shift and clamp
  assign zsum = ZSUM_W'(in_i.depth0) + ZSUM_W'(in_i.depth1) + ZSUM_W'(in_i.depth2);
  assign zq   = zsum[ZQ_W-1:0] >> shift_q;

  always_comb begin
    priority if (zsum[ZSUM_W-1]) begin
      bk_d = '0;
    end else if (zq > ZQ_W'(cdbs_pkg::BUCKETS - 1)) begin
      bk_d = cdbs_pkg::BK_W'(cdbs_pkg::BUCKETS - 1);
    end else begin
      bk_d = zq[cdbs_pkg::BK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= cdbs_pkg::SHIFT_RESET;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_i.op;
      id_q <= in_i.tri_id;
      p1_q <= p1_d;
      p2_q <= p2_d;
      bk_q <= bk_d;
    end
  end

  // fill counts: one read port, bucket without valid bit reads as zero
  assign fill_addr = cmd_i.pop_look ? pb_q : bk_q;
  assign fill_eff  = fill_vld_q ? fill_rd_q : '0;
  assign fill_inc  = fill_eff + cdbs_pkg::FILL_W'(1);
  assign full      = fill_eff >= cdbs_pkg::FILL_W'(cdbs_pkg::BUCKET_CAP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_rd || cmd_i.pop_look) begin
      fill_rd_q  <= fill_mem[fill_addr];
      fill_vld_q <= nz_q[fill_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_fin && !full) begin
      fill_mem[bk_q] <= fill_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_fin && !full) begin
      entry_mem[{bk_q, fill_eff[cdbs_pkg::SLOT_W-1:0]}] <= id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) begin
      ent_q <= entry_mem[{pb_q, slot_q[cdbs_pkg::SLOT_W-1:0]}];
    end
  end

  // valid bits double as "bucket non-empty"
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '0;
    end else if (cmd_i.emit_clr) begin
      nz_q <= '0;
    end else if (cmd_i.ins_fin && !full) begin
      nz_q[bk_q] <= 1'b1;
    end
  end

  // pop cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q   <= cdbs_pkg::BK_W'(cdbs_pkg::BUCKETS - 1);
      slot_q <= '0;
    end else if (cmd_i.emit_clr) begin
      pb_q   <= cdbs_pkg::BK_W'(cdbs_pkg::BUCKETS - 1);
      slot_q <= '0;
    end else if (cmd_i.pop_dec) begin
      pb_q   <= pb_q - cdbs_pkg::BK_W'(1);
      slot_q <= '0;
    end else if (cmd_i.pop_fin) begin
      slot_q <= slot_nxt[cdbs_pkg::FILL_W-1:0];
    end
  end

  assign slot_nxt   = {1'b0, slot_q} + (cdbs_pkg::FILL_W + 1)'(1);
  assign low_mask   = (cdbs_pkg::BUCKETS'(1) << pb_q) - cdbs_pkg::BUCKETS'(1);
  assign more_here  = slot_nxt < {1'b0, fill_rd_q};
  assign more_below = |(nz_q & low_mask);
  assign last_d     = !(more_here || more_below);

  // result register
  assign emit = cmd_i.emit_cull | cmd_i.emit_clr | cmd_i.ins_fin |
                cmd_i.pop_fin | cmd_i.emit_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      priority if (cmd_i.ins_fin) begin
        status_q <= full ? cdbs_pkg::ST_FULL : cdbs_pkg::ST_STORED;
        out_id_q <= '0;
        out_bk_q <= bk_q;
        last_q   <= 1'b0;
      end else if (cmd_i.pop_fin) begin
        status_q <= cdbs_pkg::ST_POPPED;
        out_id_q <= ent_q;
        out_bk_q <= pb_q;
        last_q   <= last_d;
      end else if (cmd_i.emit_clr) begin
        status_q <= cdbs_pkg::ST_CLEARED;
        out_id_q <= '0;
        out_bk_q <= '0;
        last_q   <= 1'b0;
      end else if (cmd_i.emit_empty) begin
        status_q <= cdbs_pkg::ST_EMPTY;
        out_id_q <= '0;
        out_bk_q <= '0;
        last_q   <= 1'b0;
      end else begin
        status_q <= cdbs_pkg::ST_CULLED;
        out_id_q <= '0;
        out_bk_q <= '0;
        last_q   <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.out_tri_id = out_id_q;
  assign out_o.out_bucket = out_bk_q;
  assign out_o.last       = last_q;

  assign sts_o.op           = op_q;
  assign sts_o.culled       = !(edge_fn > 0);
  assign sts_o.nz_cur       = nz_q[pb_q];
  assign sts_o.pb_zero      = pb_q == '0;
  assign sts_o.slot_lt_fill = slot_q < fill_rd_q;
  assign sts_o.out_free     = !out_valid_q || out_o.ready;

  `CDBS_ASSERT(a_clr_rewinds,
               cmd_i.emit_clr |=> nz_q == '0 && pb_q == cdbs_pkg::BK_W'(cdbs_pkg::BUCKETS - 1),
               "clear did not empty buckets and rewind cursor")
  `CDBS_NEVER(a_slot_range, slot_q > cdbs_pkg::FILL_W'(cdbs_pkg::BUCKET_CAP),
              "pop slot beyond bucket capacity")
  `CDBS_ASSERT(a_pop_nonempty, cmd_i.ent_rd |-> nz_q[pb_q], "entry read from an empty bucket")

endmodule

@@ src/cull_and_depth_bucket_sort.sv @@
// Cull and depth bucket sorter, top level.
//
// in_i  : op words. Insert carries tri_id, three screen vertices and three
//         depths; clear and pop use op alone. A word is taken when valid
//         and ready are high at a rising edge of clk_i.
// out_o : one result word per insert, clear and pop (op 3 gives none):
//         status, out_tri_id, out_bucket, last.
// cfg_we_i / cfg_wdata_i: writes depth_shift; write only while idle.
//
// Steps: insert decodes, reads its bucket's fill count (one read port),
// then writes back the incremented count and emits; a culled insert and
// a clear emit from decode. Pop reads the cursor bucket's fill count,
// checks the slot, reads the entry and emits it, stepping down past
// empty buckets, or emits empty at the bottom. The next word is taken
// only after the result of the last is registered.
//
// Reset (rst_ni low, async): all buckets empty, cursor at the top bucket,
// depth_shift = 5. Bucket storage is not cleared; per-bucket valid bits
// stand in for it. When the receiver stalls, the result stays in the
// output register and the next word's result waits in its final state.
module cull_and_depth_bucket_sort (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdbs_pkg::SHIFT_W-1:0]  cfg_wdata_i,
  cdbs_in_if.sink                       in_i,
  cdbs_out_if.source                    out_o
);

  cdbs_pkg::cmd_t cmd;
  cdbs_pkg::sts_t sts;
  logic           in_ready;

  // sequencer: accepts words and steps the datapath
  cdbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // products, bucket select, bucket memories, cursor, result register
  cdbs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
